>>> sv/efws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_pkg
// Shared types and constants for the earliest-free worker scheduler.
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int ID_W        = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int TIME_W      = 64;
  localparam int DUR_W       = 32;
  localparam int CFG_W       = 5;
  localparam int WORKER_W    = 4;

  // Sort key: free time first, worker number breaks ties.
  typedef struct packed {
    logic [TIME_W-1:0] ftime;
    logic [ID_W-1:0]   id;
  } key_t;

  // Handed from each cell to its right neighbor.
  typedef struct packed {
    key_t r;     // this position of the list with the popped entry taken out
    logic lt;    // r sorts before the reinserted key
    logic seen;  // the popped entry sits at or left of this cell
  } chain_t;

  function automatic logic key_lt(input key_t a, input key_t b);
    key_lt = (a < b);
  endfunction

endpackage

>>> sv/efws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_cell
// One slot of the sorted worker chain: holds a key, finds the head, shifts.
// ----------------------------------------------------------------------------
module efws_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [efws_pkg::ID_W-1:0]  init_id,
  input  logic [efws_pkg::CNT_W-1:0] n_eff,
  input  logic                     update,
  input  efws_pkg::key_t           new_key,
  input  efws_pkg::key_t           right_key,
  input  efws_pkg::chain_t         left,
  output efws_pkg::chain_t         right,
  output efws_pkg::key_t           key,
  output logic                     head
);

  efws_pkg::key_t key_next;
  logic           act;

  always_comb begin
    act       = (efws_pkg::CNT_W'(key.id) < n_eff);
    head      = act & ~left.seen;
    right.seen = left.seen | act;
    // entries right of the popped one move one place left
    right.r   = right.seen ? right_key : key;
    right.lt  = efws_pkg::key_lt(right.r, new_key);
    if (right.lt) begin
      key_next = right.r;
    end else if (left.lt) begin
      key_next = new_key;
    end else begin
      key_next = left.r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key.ftime <= '0;
      key.id    <= init_id;
    end else if (update) begin
      key <= key_next;
    end
  end

endmodule

>>> sv/earliest_free_worker_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_core
// Assigns each job word to the active worker that is free earliest.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  ---------+---------------------------------+----------
//  in       | in_valid, in_stall, duration    | job in
//  out      | out_valid, out_stall, worker,   | result out
//           | start_time                      |
//  cfg      | cfg_we, cfg_data                | active_workers write
//
//  Each word passes a pick cycle and an update cycle: the pick cycle takes
//  the head of the sorted chain, registers the result and the updated key;
//  the update cycle reinserts that key into the chain (parallel compare in
//  every cell, one shift), and no new word is taken during it.
//  Reset: cells load (0, own index), no clearing pass. A result waiting
//  on out_stall blocks the next pick only; the update cycle runs regardless.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [efws_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [efws_pkg::DUR_W-1:0]      duration,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [efws_pkg::WORKER_W-1:0]   worker,
  output logic [efws_pkg::TIME_W-1:0]     start_time
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_UPDATE = 1'b1;

  localparam int N = efws_pkg::MAX_WORKERS;

  logic                        state;
  logic [efws_pkg::CFG_W-1:0]  active_workers;
  logic [efws_pkg::CNT_W-1:0]  n_eff;
  logic                        accept;
  logic                        update;

  efws_pkg::key_t   new_key;
  efws_pkg::key_t   head_key;
  efws_pkg::key_t   cell_key [N];
  efws_pkg::key_t   right_in [N];
  efws_pkg::chain_t chain    [N+1];
  logic [N-1:0]     head;
  logic [efws_pkg::TIME_W:0] sum;

  // Clamp the worker count to 1..MAX_WORKERS.
  always_comb begin
    if (active_workers == '0) begin
      n_eff = efws_pkg::CNT_W'(1);
    end else if (int'(active_workers) > N) begin
      n_eff = efws_pkg::CNT_W'(N);
    end else begin
      n_eff = efws_pkg::CNT_W'(active_workers);
    end
  end

  assign update   = (state == S_UPDATE);
  assign in_stall = update | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  // Left edge of the chain: the first slot is always a candidate for the
  // reinserted key.
  assign chain[0].r    = new_key;
  assign chain[0].lt   = 1'b1;
  assign chain[0].seen = 1'b0;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      // Last cell sees the new key on its right, so it never sorts below it.
      if (g == N - 1) begin : g_last
        assign right_in[g] = new_key;
      end else begin : g_mid
        assign right_in[g] = cell_key[g+1];
      end

      efws_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .init_id   (efws_pkg::ID_W'(g)),
        .n_eff     (n_eff),
        .update    (update),
        .new_key   (new_key),
        .right_key (right_in[g]),
        .left      (chain[g]),
        .right     (chain[g+1]),
        .key       (cell_key[g]),
        .head      (head[g])
      );
    end
  endgenerate

  // One-hot head select.
  always_comb begin
    head_key = '0;
    for (int j = 0; j < N; j++) begin
      if (head[j]) begin
        head_key = head_key | cell_key[j];
      end
    end
  end

  // Saturating free-time update.
  assign sum = {1'b0, head_key.ftime} + (efws_pkg::TIME_W + 1)'(duration);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      active_workers <= efws_pkg::CFG_W'(1);
    end else begin
      if (cfg_we) begin
        active_workers <= cfg_data;
      end
      if (accept) begin
        state     <= S_UPDATE;
        out_valid <= 1'b1;
      end else begin
        state <= S_IDLE;
        if (out_valid && !out_stall) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      worker      <= efws_pkg::WORKER_W'(head_key.id);
      start_time  <= head_key.ftime;
      new_key.id  <= head_key.id;
      new_key.ftime <= sum[efws_pkg::TIME_W] ? '1 : sum[efws_pkg::TIME_W-1:0];
    end
  end

endmodule

>>> verif/tb_earliest_free_worker_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_earliest_free_worker_scheduler_core
// Self-checking bench for the earliest-free worker scheduler. The bench keeps
// its own copy of the per-worker free times and predicts worker and start
// time for every accepted job word. It checks each result word in order.
// Both channels idle at random, and the output is held off twice for a long
// stretch. The worker count steps through 0, 1, 16, values above 16 and
// random values between phases.
// ----------------------------------------------------------------------------

// Predicts the assignment for each accepted job and checks result words in order.
class assignment_board;
  typedef struct {
    logic [efws_pkg::WORKER_W-1:0] wkr;
    logic [efws_pkg::TIME_W-1:0]   start;
  } assignment_t;

  logic [efws_pkg::TIME_W-1:0] free_at [efws_pkg::MAX_WORKERS];
  logic [efws_pkg::CFG_W-1:0]  workers_cfg;
  assignment_t                 due_assignments [$];
  int unsigned                 bad_fields;
  int unsigned                 checked;

  function new();
    foreach (free_at[i]) free_at[i] = '0;
    workers_cfg = 1;
    bad_fields  = 0;
    checked     = 0;
  endfunction

  function void set_workers(logic [efws_pkg::CFG_W-1:0] v);
    workers_cfg = v;
  endfunction

  function void flag(string what, logic [63:0] exp_v, logic [63:0] got_v);
    bad_fields++;
    if (bad_fields <= 10)
      $display("MISMATCH %s: expected %0d (0x%0h), got %0d (0x%0h) at %0t",
               what, exp_v, exp_v, got_v, got_v, $realtime);
  endfunction

  function void book_job(logic [efws_pkg::DUR_W-1:0] dur);
    int                          n;
    int                          best;
    logic [efws_pkg::TIME_W:0]   sum;
    assignment_t                 a;
    // zero counts as one worker, anything past the array counts as all
    n = (workers_cfg == 0) ? 1 : int'(workers_cfg);
    if (n > efws_pkg::MAX_WORKERS) n = efws_pkg::MAX_WORKERS;
    best = 0;
    for (int k = 1; k < n; k++)
      if (free_at[k] < free_at[best]) best = k;
    a.wkr   = best[efws_pkg::WORKER_W-1:0];
    a.start = free_at[best];
    due_assignments.push_back(a);
    sum = {1'b0, free_at[best]} + {{(efws_pkg::TIME_W+1-efws_pkg::DUR_W){1'b0}}, dur};
    free_at[best] = sum[efws_pkg::TIME_W] ? '1 : sum[efws_pkg::TIME_W-1:0];
  endfunction

  function void check_assignment(logic [efws_pkg::WORKER_W-1:0] wkr,
                                 logic [efws_pkg::TIME_W-1:0]   start);
    assignment_t a;
    checked++;
    if (due_assignments.size() == 0) begin
      flag("unexpected result, worker", 0, wkr);
      return;
    end
    a = due_assignments.pop_front();
    if (wkr !== a.wkr) flag("worker", a.wkr, wkr);
    if (start !== a.start) flag("start_time", a.start, start);
  endfunction

  function int pending();
    return due_assignments.size();
  endfunction
endclass

module tb_earliest_free_worker_scheduler_core;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_TAIL  = 4;     // pick + update, with margin
  localparam int LONG_HOLD   = 400;   // output hold-off that backs up the input
  localparam int PHASE_JOBS  = 165;
  localparam int RAND_PHASES = 10;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [efws_pkg::CFG_W-1:0]      cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [efws_pkg::DUR_W-1:0]      duration;
  logic                            out_valid;
  logic                            out_stall;
  logic [efws_pkg::WORKER_W-1:0]   worker;
  logic [efws_pkg::TIME_W-1:0]     start_time;

  assignment_board board;
  int unsigned     jobs_sent;
  int unsigned     results_seen;
  int unsigned     settings_used;
  int unsigned     long_holds;
  bit              burst;

  earliest_free_worker_scheduler_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .duration   (duration),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .worker     (worker),
    .start_time (start_time)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly small durations so free times stay close and ties keep turning up;
  // the rest cover the full 32-bit range, all-ones included.
  function automatic logic [efws_pkg::DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3)  return '0;
    if (r < 10) return $urandom_range(1, 15);
    if (r < 15) return $urandom_range(16, 2000);
    if (r == 15) return '1;
    return $urandom;
  endfunction

  // Offers one job word and holds it until taken. Valid stays high when
  // no gap follows, so back-to-back words never drop it.
  task automatic send_job(input logic [efws_pkg::DUR_W-1:0] d);
    int gap;
    in_valid <= 1'b1;
    duration <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.book_job(d);
    jobs_sent++;
    gap = burst ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      duration <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every booked job has its result, then lets the last update
  // cycle settle so the register write lands on an idle block.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic set_workers(input logic [efws_pkg::CFG_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    board.set_workers(v);
    settings_used++;
  endtask

  // Result side: compare every word taken off the output.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      board.check_assignment(worker, start_time);
      results_seen <= results_seen + 1;
    end
  end

  // Receiver: random hold-offs, long release stretches now and then, and
  // two long holds mid-phase so the core fills and stalls its input.
  initial begin : result_sink
    int hold;
    int run;
    int hold_mark [2];
    hold_mark[0] = 300;
    hold_mark[1] = 1100;
    out_stall    = 1'b0;
    long_holds   = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_holds < 2 && results_seen >= hold_mark[long_holds]) begin
        hold = LONG_HOLD;
        long_holds++;
      end else begin
        hold = idle_len();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog: any handshake on either channel resets the count.
  always @(posedge clk) begin : stuck_guard
    int idle_cycles;
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, board.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [efws_pkg::DUR_W-1:0] corner_durs [17];
    logic [efws_pkg::CFG_W-1:0] phase_cfg   [8];
    logic [efws_pkg::CFG_W-1:0] v;

    // Fresh counters: the first job takes worker 0 at time 0 and the
    // all-ones job parks it far out; the rest spread over the idle workers,
    // and a zero duration leaves its worker first in line for the next job.
    corner_durs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                    32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h0000_0002,
                    32'h0000_0003, 32'h0000_0000, 32'h0000_0004, 32'hFFFF_FFFE,
                    32'h0000_0005, 32'h0000_0006, 32'h0000_0007, 32'h0000_0008,
                    32'h0000_0000};
    // count of 0 and anything above 16 clamp; 1 and 16 are the true limits
    phase_cfg = '{5'd16, 5'd3, 5'd0, 5'd17, 5'd1, 5'd8, 5'd31, 5'd16};

    board         = new();
    jobs_sent     = 0;
    results_seen  = 0;
    settings_used = 0;
    burst         = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    duration      = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all workers from a cleared state, then the clamped counts.
    // Worker 0 keeps its far-out time while others leave and rejoin.
    set_workers(5'd16);
    foreach (corner_durs[i]) send_job(corner_durs[i]);
    drain();
    set_workers(5'd0);
    send_job(32'h0000_0000);
    send_job(32'hFFFF_FFFF);
    drain();
    set_workers(5'd31);
    send_job(32'h0000_0001);
    send_job(32'h0000_0000);
    drain();
    set_workers(5'd1);
    send_job(32'h0000_0009);
    send_job(32'h1234_5678);
    drain();

    // Random phases; free times carry over from phase to phase.
    for (int p = 0; p < RAND_PHASES; p++) begin
      v = (p < 8) ? phase_cfg[p] : 5'($urandom_range(0, 31));
      set_workers(v);
      for (int j = 0; j < PHASE_JOBS; j++) begin
        // sender runs without gaps for about one chunk in four
        if (j % 40 == 0) burst = ($urandom_range(0, 3) == 0);
        send_job(pick_duration());
      end
      burst = 1'b0;
      drain();
    end

    repeat (DRAIN_TAIL * 2) @(posedge clk);

    if (board.pending() != 0)
      board.flag("results never delivered", 0, board.pending());
    $display("Summary: %0d jobs, %0d results checked, %0d worker-count writes",
             jobs_sent, board.checked, settings_used);
    $display("Summary: counts 0, 1, 16, 17, 31 and random; %0d long output holds",
             long_holds);
    if (board.bad_fields == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
